// ----- rtl/wsfd_pkg.sv -----
package wsfd_pkg;

    localparam int LEN_WIDTH = 64;

    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_PING  = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic       has_data;
        logic       last;
    } out_item_t;

endpackage

// ----- rtl/wsfd_parse.sv -----
module wsfd_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  wsfd_pkg::in_item_t item,
    output logic               push,
    output wsfd_pkg::out_item_t res
);

    localparam logic [2:0] PH_HDR = 3'd0;
    localparam logic [2:0] PH_LEN = 3'd1;
    localparam logic [2:0] PH_EXT = 3'd2;
    localparam logic [2:0] PH_KEY = 3'd3;
    localparam logic [2:0] PH_PAY = 3'd4;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'ha;

    localparam logic [6:0] LC_EXT16 = 7'd126;
    localparam logic [6:0] LC_EXT64 = 7'd127;

    localparam int LW = wsfd_pkg::LEN_WIDTH;

    logic          link_reg,   link_next;
    logic [2:0]    phase_reg,  phase_next;
    logic [2:0]    hc_reg,     hc_next;
    logic          final_reg,  final_next;
    logic [3:0]    op_reg,     op_next;
    logic          masked_reg, masked_next;
    logic [6:0]    lc_reg,     lc_next;
    logic [LW-1:0] len_reg,    len_next;
    logic          ovf_reg,    ovf_next;
    logic [31:0]   key_reg,    key_next;
    logic [1:0]    mi_reg,     mi_next;

    logic          is_text, is_ping, is_pong, is_close;
    logic [1:0]    kind_ev;
    logic [7:0]    b;
    logic [7:0]    key_byte;
    logic [3:0]    hc_inc;
    logic [3:0]    hc_target;
    logic          hdr_done;
    logic [LW-1:0] hdr_len;
    logic          hdr_ovf;
    logic          frm_end;
    logic          pay_end;

    assign b        = item.rx_byte;
    assign is_text  = (op_reg == OP_TEXT) && final_reg;
    assign is_ping  = (op_reg == OP_PING);
    assign is_pong  = (op_reg == OP_PONG);
    assign is_close = (op_reg == OP_CLOSE);
    assign kind_ev  = is_text ? wsfd_pkg::EV_TEXT :
                      is_ping ? wsfd_pkg::EV_PING :
                      is_close ? wsfd_pkg::EV_CLOSE : wsfd_pkg::EV_ERROR;
    assign hc_inc    = {1'b0, hc_reg} + 4'd1;
    assign hc_target = (lc_reg == LC_EXT16) ? 4'd2 : 4'd8;
    assign pay_end   = (len_reg == LW'(1));

    always_comb
    begin
        case (mi_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        link_next   = link_reg;
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        final_next  = final_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        lc_next     = lc_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        mi_next     = mi_reg;
        hdr_done    = 1'b0;
        hdr_len     = len_reg;
        hdr_ovf     = ovf_reg;
        frm_end     = 1'b0;
        push        = 1'b0;
        res         = '0;

        if (take) begin
            if (item.cmd) begin
                link_next   = 1'b1;
                phase_next  = PH_HDR;
                hc_next     = '0;
                final_next  = 1'b0;
                op_next     = '0;
                masked_next = 1'b0;
                lc_next     = '0;
                len_next    = '0;
                ovf_next    = 1'b0;
                key_next    = '0;
                mi_next     = '0;
            end else if (link_reg) begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        masked_next = b[7];
                        lc_next     = b[6:0];
                        hc_next     = '0;
                        key_next    = '0;
                        mi_next     = '0;
                        ovf_next    = 1'b0;
                        if (b[6:0] == LC_EXT16 || b[6:0] == LC_EXT64) begin
                            len_next   = '0;
                            phase_next = PH_EXT;
                        end else begin
                            len_next = LW'(b[6:0]);
                            if (b[7]) begin
                                phase_next = PH_KEY;
                            end else begin
                                hdr_done = 1'b1;
                                hdr_len  = LW'(b[6:0]);
                                hdr_ovf  = 1'b0;
                            end
                        end
                    end
                    PH_EXT:
                    begin
                        // bits shifted past the top mean the length is too wide
                        len_next = {len_reg[LW-9:0], b};
                        ovf_next = ovf_reg | (len_reg[LW-1 -: 8] != 8'd0);
                        hc_next  = hc_inc[2:0];
                        if (hc_inc >= hc_target) begin
                            hc_next = '0;
                            if (masked_reg) begin
                                phase_next = PH_KEY;
                            end else begin
                                hdr_done = 1'b1;
                                hdr_len  = {len_reg[LW-9:0], b};
                                hdr_ovf  = ovf_reg | (len_reg[LW-1 -: 8] != 8'd0);
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        key_next = {key_reg[23:0], b};
                        hc_next  = hc_inc[2:0];
                        if (hc_inc >= 4'd4) begin
                            hdr_done = 1'b1;
                        end
                    end
                    PH_PAY:
                    begin
                        mi_next  = mi_reg + 2'd1;
                        len_next = len_reg - LW'(1);
                        if (pay_end) begin
                            phase_next = PH_HDR;
                        end
                        if (is_text || is_ping) begin
                            push             = 1'b1;
                            res.event_res    = kind_ev;
                            res.payload_byte = b ^ key_byte;
                            res.has_data     = 1'b1;
                            res.last         = pay_end;
                        end else if (pay_end) begin
                            frm_end = 1'b1;
                        end
                    end
                    default:
                    begin
                        final_next = b[7];
                        op_next    = b[3:0];
                        phase_next = PH_LEN;
                    end
                endcase

                if (hdr_done) begin
                    hc_next = '0;
                    mi_next = '0;
                    if (hdr_ovf) begin
                        phase_next    = PH_HDR;
                        link_next     = 1'b0;
                        push          = 1'b1;
                        res.event_res = wsfd_pkg::EV_ERROR;
                        res.last      = 1'b1;
                    end else if (hdr_len == '0) begin
                        frm_end = 1'b1;
                    end else begin
                        phase_next = PH_PAY;
                        len_next   = hdr_len;
                    end
                end

                if (frm_end) begin
                    phase_next = PH_HDR;
                    if (!is_pong) begin
                        if (!is_text && !is_ping) begin
                            link_next = 1'b0;
                        end
                        push          = 1'b1;
                        res.event_res = kind_ev;
                        res.last      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            link_reg   <= 1'b0;
            phase_reg  <= PH_HDR;
            hc_reg     <= '0;
            final_reg  <= 1'b0;
            op_reg     <= '0;
            masked_reg <= 1'b0;
            lc_reg     <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= '0;
            mi_reg     <= '0;
        end else begin
            link_reg   <= link_next;
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            final_reg  <= final_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            lc_reg     <= lc_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            mi_reg     <= mi_next;
        end
    end

endmodule

// ----- rtl/wsfd_obuf.sv -----
module wsfd_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsfd_pkg::out_item_t push_item,
    output logic                full,
    output logic                res_valid,
    input  logic                res_stall,
    output wsfd_pkg::out_item_t res
);

    logic                main_v_reg, main_v_next;
    logic                skid_v_reg, skid_v_next;
    wsfd_pkg::out_item_t main_reg,   main_next;
    wsfd_pkg::out_item_t skid_reg,   skid_next;
    logic                pop;

    assign pop       = main_v_reg && !res_stall;
    assign full      = skid_v_reg;
    assign res_valid = main_v_reg;
    assign res       = main_reg;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (!main_v_reg || pop) begin
            if (skid_v_reg) begin
                main_v_next = 1'b1;
                main_next   = skid_reg;
                skid_v_next = 1'b0;
            end else begin
                main_v_next = push;
                main_next   = push_item;
            end
        end else if (push) begin
            skid_v_next = 1'b1;
            skid_next   = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/websocket_frame_deframer_unit.sv -----
// Receive-side WebSocket frame parser. One received byte (or an open command)
// is taken per item, one item per clock while item_stall is low; each item
// updates the parser state and yields at most one result, which is registered
// in the output buffer before it appears on res. Results pass through a
// two-entry output buffer, so input keeps flowing while one result waits;
// item_stall rises only when both entries hold results. Final text and ping
// payloads come out unmasked, one byte per result; close and error frames
// give a single event and close the link until the next open command.
// Extended lengths wider than LEN_WIDTH end in an error event.
module websocket_frame_deframer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  wsfd_pkg::in_item_t  item,
    output logic                res_valid,
    input  logic                res_stall,
    output wsfd_pkg::out_item_t res
);

    logic                take;
    logic                push;
    logic                full;
    wsfd_pkg::out_item_t push_item;

    assign item_stall = full;
    assign take       = item_valid && !full;

    wsfd_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .push  (push),
        .res   (push_item)
    );

    wsfd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
